@@ rtl/motor_runaway_stall_detector_defines.svh @@
// Assertion macros used by the back stage (msd_back).
`ifndef MOTOR_RUNAWAY_STALL_DETECTOR_DEFINES_SVH
`define MOTOR_RUNAWAY_STALL_DETECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/msd_pkg.sv @@
package msd_pkg;

    localparam int JOINT_COUNT_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int JOINT_W     = 3;
    localparam int MODE_W      = 3;
    localparam int EFFORT_W    = 16;
    localparam int VEL_W       = 24;
    localparam int ANGLE_W     = 24;
    localparam int TIME_W      = 32;
    localparam int EFFORT_THR_W = 16;
    localparam int VEL_LIMIT_W = 23;
    localparam int ERR_THR_W   = 24;
    localparam int WINDOW_W    = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POSITION = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HOLD     = 3'd2;

    localparam logic FUNC_CLEAR = 1'b1;

    localparam logic [EFFORT_THR_W-1:0] EFFORT_THR_RST = 16'd9830;
    localparam logic [VEL_LIMIT_W-1:0]  VEL_LIMIT_RST  = 23'd192;
    localparam logic [ERR_THR_W-1:0]    ERR_THR_RST    = 24'd512;
    localparam logic [WINDOW_W-1:0]     WINDOW_RST     = 16'd1500;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_EFFORT_THR = 2'd0,
        REG_VEL_LIMIT  = 2'd1,
        REG_ERR_THR    = 2'd2,
        REG_WINDOW     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [EFFORT_THR_W-1:0] effort_thr;
        logic [VEL_LIMIT_W-1:0]  vel_limit;
        logic [ERR_THR_W-1:0]    err_thr;
    } thresholds_t;

    typedef struct packed {
        logic               func;
        logic               joint_ok;
        logic [JOINT_W-1:0] joint;
        logic               idle;
        logic               suspicious;
        logic [TIME_W-1:0]  now;
    } front_item_t;

    typedef struct packed {
        logic [JOINT_W-1:0] joint;
        logic               raised;
        logic               faulted;
        logic               straining;
    } result_t;

endpackage

@@ rtl/motor_runaway_stall_detector.sv @@
// Channel   Handshake            Payload
// input     push / full          func, joint_index, mode, effort, velocity, setpoint,
//                                angle, now_ms
// result    empty / pop          joint_echo, fault_raised, is_faulted, is_straining
// config    cfg_write            cfg_index, cfg_data
//
// One item is accepted per cycle while full is low. Its result passes through the mid queue
// and the result queue before it is shown on the result ports.
// The back stage reads the joint state table combinationally and updates it at the transfer, so samples for the
// same joint may follow each other without a gap.
// A stalled result side fills the two queues; full then rises.
// Reset clears the joint flags and loads the register defaults; no clearing pass.
module motor_runaway_stall_detector #(
    parameter int JOINT_COUNT = msd_pkg::JOINT_COUNT_DEF,
    parameter int QUEUE_DEPTH = msd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  func,
    input  logic        [msd_pkg::JOINT_W-1:0]    joint_index,
    input  logic        [msd_pkg::MODE_W-1:0]     mode,
    input  logic signed [msd_pkg::EFFORT_W-1:0]   effort,
    input  logic signed [msd_pkg::VEL_W-1:0]      velocity,
    input  logic signed [msd_pkg::ANGLE_W-1:0]    setpoint,
    input  logic signed [msd_pkg::ANGLE_W-1:0]    angle,
    input  logic        [msd_pkg::TIME_W-1:0]     now_ms,
    output logic                                  empty,
    input  logic                                  pop,
    output logic        [msd_pkg::JOINT_W-1:0]    joint_echo,
    output logic                                  fault_raised,
    output logic                                  is_faulted,
    output logic                                  is_straining,
    input  logic                                  cfg_write,
    input  logic        [msd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic        [msd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import msd_pkg::*;

    logic [EFFORT_THR_W-1:0] effort_thr_reg;
    logic [VEL_LIMIT_W-1:0]  vel_limit_reg;
    logic [ERR_THR_W-1:0]    err_thr_reg;
    logic [WINDOW_W-1:0]     window_reg;
    thresholds_t             thr;
    front_item_t             front_item;
    front_item_t             back_item;
    logic                    mid_empty;
    logic                    mid_pop;
    logic                    res_full;
    logic                    res_push;
    result_t                 back_res;
    result_t                 out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            effort_thr_reg <= EFFORT_THR_RST;
            vel_limit_reg  <= VEL_LIMIT_RST;
            err_thr_reg    <= ERR_THR_RST;
            window_reg     <= WINDOW_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_EFFORT_THR: effort_thr_reg <= cfg_data[EFFORT_THR_W-1:0];
                REG_VEL_LIMIT:  vel_limit_reg  <= cfg_data[VEL_LIMIT_W-1:0];
                REG_ERR_THR:    err_thr_reg    <= cfg_data[ERR_THR_W-1:0];
                REG_WINDOW:     window_reg     <= cfg_data[WINDOW_W-1:0];
                default:        window_reg     <= window_reg;
            endcase
        end
    end

    assign thr.effort_thr = effort_thr_reg;
    assign thr.vel_limit  = vel_limit_reg;
    assign thr.err_thr    = err_thr_reg;

    msd_front #(
        .JOINT_COUNT (JOINT_COUNT)
    ) u_front (
        .func        (func),
        .joint_index (joint_index),
        .mode        (mode),
        .effort      (effort),
        .velocity    (velocity),
        .setpoint    (setpoint),
        .angle       (angle),
        .now_ms      (now_ms),
        .thr         (thr),
        .item        (front_item)
    );

    msd_fifo #(
        .WIDTH ($bits(front_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .wdata (front_item),
        .pop   (mid_pop),
        .empty (mid_empty),
        .rdata (back_item)
    );

    msd_back #(
        .JOINT_COUNT (JOINT_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (back_item),
        .item_valid (!mid_empty),
        .item_pop   (mid_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (back_res),
        .window     (window_reg)
    );

    msd_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata (back_res),
        .pop   (pop),
        .empty (empty),
        .rdata (out_res)
    );

    assign joint_echo   = out_res.joint;
    assign fault_raised = out_res.raised;
    assign is_faulted   = out_res.faulted;
    assign is_straining = out_res.straining;

endmodule

@@ rtl/msd_fifo.sv @@
module msd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_ok;
    logic             pop_ok;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ rtl/msd_front.sv @@
module msd_front #(
    parameter int JOINT_COUNT = 8
) (
    input  logic                                      func,
    input  logic        [msd_pkg::JOINT_W-1:0]        joint_index,
    input  logic        [msd_pkg::MODE_W-1:0]         mode,
    input  logic signed [msd_pkg::EFFORT_W-1:0]       effort,
    input  logic signed [msd_pkg::VEL_W-1:0]          velocity,
    input  logic signed [msd_pkg::ANGLE_W-1:0]        setpoint,
    input  logic signed [msd_pkg::ANGLE_W-1:0]        angle,
    input  logic        [msd_pkg::TIME_W-1:0]         now_ms,
    input  msd_pkg::thresholds_t                      thr,
    output msd_pkg::front_item_t                      item
);

    import msd_pkg::*;

    logic signed [EFFORT_W:0]  eff_ext;
    logic        [EFFORT_W:0]  eff_mag;
    logic signed [VEL_W:0]     vel_ext;
    logic        [VEL_W:0]     vel_mag;
    logic signed [ANGLE_W:0]   pos_err;
    logic        [ANGLE_W:0]   err_mag;
    logic                      pushing;
    logic                      still;
    logic                      holding;
    logic                      on_target;

    assign eff_ext = {effort[EFFORT_W-1], effort};
    assign eff_mag = eff_ext[EFFORT_W] ? $unsigned(-eff_ext) : $unsigned(eff_ext);
    assign vel_ext = {velocity[VEL_W-1], velocity};
    assign vel_mag = vel_ext[VEL_W] ? $unsigned(-vel_ext) : $unsigned(vel_ext);
    assign pos_err = {setpoint[ANGLE_W-1], setpoint} - {angle[ANGLE_W-1], angle};
    assign err_mag = pos_err[ANGLE_W] ? $unsigned(-pos_err) : $unsigned(pos_err);

    assign pushing   = (eff_mag >= {1'b0, thr.effort_thr});
    assign still     = (vel_mag <= {2'b0, thr.vel_limit});
    assign holding   = (mode == MODE_POSITION) || (mode == MODE_HOLD);
    assign on_target = (err_mag < {1'b0, thr.err_thr});

    always_comb
    begin
        item.func       = func;
        item.joint_ok   = (int'(joint_index) < JOINT_COUNT);
        item.joint      = joint_index;
        item.idle       = (mode == MODE_IDLE);
        item.suspicious = pushing && still && !(holding && on_target);
        item.now        = now_ms;
    end

endmodule

@@ rtl/msd_back.sv @@
`include "motor_runaway_stall_detector_defines.svh"

module msd_back #(
    parameter int JOINT_COUNT = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  msd_pkg::front_item_t                item,
    input  logic                                item_valid,
    output logic                                item_pop,
    input  logic                                res_full,
    output logic                                res_push,
    output msd_pkg::result_t                    res,
    input  logic [msd_pkg::WINDOW_W-1:0]        window
);

    import msd_pkg::*;

    localparam int STORE_DEPTH = (JOINT_COUNT < (1 << JOINT_W)) ? JOINT_COUNT : (1 << JOINT_W);
    localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [STORE_DEPTH-1:0] strain_reg, strain_next;
    logic [STORE_DEPTH-1:0] fault_reg, fault_next;
    logic [TIME_W-1:0]      start_reg [STORE_DEPTH];
    logic                   start_we;
    logic                   go;
    logic                   raised;
    logic [IDX_W-1:0]       idx;
    logic [TIME_W-1:0]      elapsed;

    assign go       = item_valid && !res_full;
    assign item_pop = go;
    assign res_push = go;
    assign idx      = item.joint[IDX_W-1:0];
    assign elapsed  = item.now - start_reg[idx];

    always_comb
    begin
        strain_next = strain_reg;
        fault_next  = fault_reg;
        start_we    = 1'b0;
        raised      = 1'b0;
        if (go && item.joint_ok)
        begin
            if (item.func == FUNC_CLEAR)
            begin
                fault_next[idx]  = 1'b0;
                strain_next[idx] = 1'b0;
            end
            else if (item.idle || fault_reg[idx] || !item.suspicious)
            begin
                strain_next[idx] = 1'b0;
            end
            else if (!strain_reg[idx])
            begin
                strain_next[idx] = 1'b1;
                start_we         = 1'b1;
            end
            else if (elapsed >= {{(TIME_W - WINDOW_W){1'b0}}, window})
            begin
                fault_next[idx]  = 1'b1;
                strain_next[idx] = 1'b0;
                raised           = 1'b1;
            end
        end
        res.joint      = item.joint;
        res.raised     = raised;
        res.faulted    = item.joint_ok && fault_next[idx];
        res.straining  = item.joint_ok && strain_next[idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strain_reg <= '0;
            fault_reg  <= '0;
        end
        else
        begin
            strain_reg <= strain_next;
            fault_reg  <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_we)
        begin
            start_reg[idx] <= item.now;
        end
    end

    `MSD_ASSERT_NOW(a_flags_exclusive, 1'b1, ((fault_reg & strain_reg) == '0), "joint both faulted and straining")
    `MSD_ASSERT_NOW(a_raise_sets_fault, (go && res.raised), (res.faulted && !res.straining), "raised transfer without fault flag")
    `MSD_ASSERT_NEXT(a_clear_takes, (go && item.joint_ok && (item.func == FUNC_CLEAR)), (fault_reg[$past(idx)] == 1'b0), "clear left fault flag set")

endmodule
